// File: hdl/key_tone_synth_with_envelope_defines.svh
// Assertion macros shared by the key tone synthesiser RTL
`ifndef KEY_TONE_SYNTH_WITH_ENVELOPE_DEFINES_SVH
`define KEY_TONE_SYNTH_WITH_ENVELOPE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, disabled while rst_n is low
`define KTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, disabled while rst_n is low
`define KTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KTS_ASSERT_IMPL(label, ante, cons, msg)
`define KTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/kts_pkg.sv
// Types, constants and elaboration-time tables for the key tone synthesiser
package kts_pkg;

  localparam int PHASE_BITS_DEF = 24;
  localparam int SINE_ENTRIES   = 256;
  localparam int QUARTER        = SINE_ENTRIES / 4;
  localparam int SINE_AW        = $clog2(4 * QUARTER);
  localparam int IDX_W          = $clog2(QUARTER + 1);
  localparam int NUM_KEYS       = 13;
  localparam int KEY_W          = 4;
  localparam int MAG_W          = 15;
  localparam int ENV_W          = 16;
  localparam int SAMPLE_W       = 16;

  localparam logic [ENV_W-1:0] ENV_ONE = 16'h8000;

  localparam longint unsigned SAMPLE_HZ_CENTI = 64'd1600000;

  // Serial multiplier geometry: 4-bit digits of the B operand
  localparam int MUL_AW    = 32;
  localparam int MUL_BW    = 16;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int DIGIT_W   = 4;
  localparam int MUL_STEPS = MUL_BW / DIGIT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;

  localparam logic [14:0] ATTACK_RST    = 15'd393;
  localparam logic [14:0] RELEASE_RST   = 15'd82;
  localparam logic [14:0] AMPLITUDE_RST = 15'd11000;
  localparam logic [15:0] THRESHOLD_RST = 16'd16;

  typedef struct packed {
    logic              key_pressed;
    logic [KEY_W-1:0]  key_index;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sounding;
  } out_t;

  typedef int unsigned note_tab_t [0:NUM_KEYS-1];
  typedef logic [31:0] step_tab_t [0:NUM_KEYS-1];
  typedef logic [MAG_W-1:0] qrom_t [0:QUARTER];

  // Note pitches in centi-hertz: white keys C4..C5, then black keys C#4..A#4
  localparam note_tab_t NOTE_CENTI_HZ = '{
    26163, 29366, 32963, 34923, 39200, 44000, 49388, 52325,
    27718, 31113, 36999, 41530, 46616
  };

  // Tuning words round(f * 2^pbits / 16000), half rounds up
  function automatic step_tab_t build_steps(int unsigned pbits);
    step_tab_t        tab;
    longint unsigned  num;
    for (int k = 0; k < NUM_KEYS; k++) begin
      num = (longint'(NOTE_CENTI_HZ[k]) << pbits) + SAMPLE_HZ_CENTI / 2;
      tab[k] = 32'(num / SAMPLE_HZ_CENTI);
    end
    return tab;
  endfunction

  // round(32767 * sin(pi/2 * i / QUARTER)) by a Q30 Taylor series
  function automatic logic [MAG_W-1:0] quarter_sine(int unsigned i);
    longint unsigned u;
    longint unsigned theta;
    longint unsigned theta2;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    u      = (longint'(i) << 30) / QUARTER;
    theta  = (u * 64'd1686629713) >> 30;
    theta2 = (theta * theta) >> 30;
    term   = theta;
    acc    = longint'(theta);
    term = ((term * theta2) >> 30) / 6;   acc = acc - longint'(term);
    term = ((term * theta2) >> 30) / 20;  acc = acc + longint'(term);
    term = ((term * theta2) >> 30) / 42;  acc = acc - longint'(term);
    term = ((term * theta2) >> 30) / 72;  acc = acc + longint'(term);
    term = ((term * theta2) >> 30) / 110; acc = acc - longint'(term);
    term = ((term * theta2) >> 30) / 156; acc = acc + longint'(term);
    term = ((term * theta2) >> 30) / 210; acc = acc - longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    v = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return MAG_W'(v);
  endfunction

  function automatic qrom_t build_rom();
    qrom_t rom;
    for (int i = 0; i <= QUARTER; i++) begin
      rom[i] = quarter_sine(i);
    end
    return rom;
  endfunction

  localparam qrom_t QROM = build_rom();

endpackage

// File: hdl/kts_mul.sv
// Digit-serial unsigned multiplier, one 4-bit digit of B per cycle
module kts_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kts_pkg::MUL_AW-1:0]   a,
  input  logic [kts_pkg::MUL_BW-1:0]   b,
  output logic                         done,
  output logic [kts_pkg::MUL_PW-1:0]   product
);

  localparam int AW    = kts_pkg::MUL_AW;
  localparam int BW    = kts_pkg::MUL_BW;
  localparam int DW    = kts_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(kts_pkg::MUL_STEPS);

  logic [AW-1:0]    a_r;
  logic [AW-1:0]    hi_r, hi_nxt;
  logic [BW-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [AW+DW-1:0] part;

  // Add one partial product and shift the pair right by a digit
  always_comb begin
    part   = {{DW{1'b0}}, hi_r} + (AW+DW)'(a_r) * (AW+DW)'(lo_r[DW-1:0]);
    hi_nxt = part[AW+DW-1:DW];
    lo_nxt = {part[DW-1:0], lo_r[BW-1:DW]};
  end

  // Hold operands, step the digit count, flag the finished product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(kts_pkg::MUL_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(kts_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

// File: hdl/key_tone_synth_with_envelope.sv
// A sounding tick runs three passes of the 4-digit serial multiplier (envelope, sine x envelope,
//   x amplitude) and then the emit state; a silent tick goes straight to the emit state.
// in_stall is high outside the idle state, so a new tick is taken only once the last one is emitted.
// A new tick is taken while the previous result still waits in the output register.
// Synchronous active-low reset: phase, envelope and step clear to zero, registers load
//   their defaults, the output register empties.
`include "key_tone_synth_with_envelope_defines.svh"

module key_tone_synth_with_envelope #(
  parameter int PHASE_BITS = kts_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kts_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kts_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ENV_W = kts_pkg::ENV_W;
  localparam int MAG_W = kts_pkg::MAG_W;
  localparam int IDX_W = kts_pkg::IDX_W;
  localparam int SW    = kts_pkg::SINE_AW;
  localparam int PW    = kts_pkg::MUL_PW;
  localparam kts_pkg::step_tab_t STEP_TAB = kts_pkg::build_steps(PHASE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV,
    S_MAG,
    S_AMP,
    S_EMIT
  } state_t;

  state_t                     state_r;
  logic [14:0]                attack_r, release_r, amp_r;
  logic [15:0]                thr_r;
  logic [PHASE_BITS-1:0]      phase_r, step_r;
  logic [ENV_W-1:0]           env_r, env_nxt;
  logic                       held_r, neg_r;
  logic [kts_pkg::SAMPLE_W-1:0] res_sample_r;
  logic                       res_sounding_r;
  logic                       out_valid_r;
  kts_pkg::out_t              out_data_r;

  logic                       in_xfer, held_in, silent;
  logic [ENV_W-1:0]           diff, env_delta;
  logic [31:0]                env_rnd;
  logic [SW-1:0]              sine_addr;
  logic [IDX_W-1:0]           rom_idx;
  logic [MAG_W-1:0]           rom_mag;
  logic [kts_pkg::SAMPLE_W-1:0] mag_m, sample_val;

  logic                       mul_start, mul_done;
  logic [kts_pkg::MUL_AW-1:0] mul_a;
  logic [kts_pkg::MUL_BW-1:0] mul_b;
  logic [PW-1:0]              mul_prod;

  kts_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign held_in   = in_data.key_pressed &&
                     (in_data.key_index < kts_pkg::KEY_W'(kts_pkg::NUM_KEYS));
  assign silent    = !held_in && (env_r < thr_r);

  // Envelope step from the first multiplier pass
  always_comb begin
    diff      = kts_pkg::ENV_ONE - env_r;
    env_rnd   = mul_prod[31:0] + (held_r ? 32'd0 : 32'd32767);
    env_delta = env_rnd[30:15];
    env_nxt   = held_r ? env_r + env_delta : env_r - env_delta;
  end

  // Quarter-wave lookup: mirror odd quadrants; the top phase bit marks the negative half
  always_comb begin
    sine_addr = phase_r[PHASE_BITS-1 -: SW];
    rom_idx   = sine_addr[SW-2] ?
                IDX_W'(kts_pkg::QUARTER) - IDX_W'(sine_addr[SW-3:0]) :
                IDX_W'(sine_addr[SW-3:0]);
    rom_mag   = kts_pkg::QROM[rom_idx];
  end

  // Final magnitude and sign
  always_comb begin
    mag_m      = mul_prod[45:30];
    sample_val = neg_r ? 16'd0 - mag_m : mag_m;
  end

  // Sequence the multiplier passes
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        mul_start = in_xfer && !silent;
        mul_a     = 32'(held_in ? diff : env_r);
        mul_b     = 16'(held_in ? attack_r : release_r);
      end
      S_ENV: begin
        mul_start = mul_done;
        mul_a     = 32'(env_nxt);
        mul_b     = 16'(rom_mag);
      end
      S_MAG: begin
        mul_start = mul_done;
        mul_a     = mul_prod[31:0];
        mul_b     = 16'(amp_r);
      end
      S_AMP, S_EMIT: begin
        mul_start = 1'b0;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= kts_pkg::ATTACK_RST;
      release_r <= kts_pkg::RELEASE_RST;
      amp_r     <= kts_pkg::AMPLITUDE_RST;
      thr_r     <= kts_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kts_pkg::REG_ATTACK:    attack_r  <= cfg_data[14:0];
        kts_pkg::REG_RELEASE:   release_r <= cfg_data[14:0];
        kts_pkg::REG_AMPLITUDE: amp_r     <= cfg_data[14:0];
        kts_pkg::REG_THRESHOLD: thr_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // State, tone state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= '0;
      step_r         <= '0;
      env_r          <= '0;
      held_r         <= 1'b0;
      neg_r          <= 1'b0;
      res_sounding_r <= 1'b0;
      res_sample_r   <= '0;
      out_valid_r    <= 1'b0;
      out_data_r     <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            held_r <= held_in;
            if (held_in) begin
              step_r <= STEP_TAB[in_data.key_index][PHASE_BITS-1:0];
            end
            if (silent) begin
              res_sample_r   <= '0;
              res_sounding_r <= 1'b0;
              state_r        <= S_EMIT;
            end else begin
              state_r <= S_ENV;
            end
          end
        end
        S_ENV: begin
          if (mul_done) begin
            env_r   <= env_nxt;
            neg_r   <= sine_addr[SW-1];
            state_r <= S_MAG;
          end
        end
        S_MAG: begin
          if (mul_done) begin
            state_r <= S_AMP;
          end
        end
        S_AMP: begin
          if (mul_done) begin
            res_sample_r   <= sample_val;
            res_sounding_r <= 1'b1;
            phase_r        <= phase_r + step_r;
            state_r        <= S_EMIT;
          end
        end
        S_EMIT: begin
          // load the payload on transfer into the output register
          if (!out_valid_r || !out_stall) begin
            out_valid_r         <= 1'b1;
            out_data_r.sample   <= $signed(res_sample_r);
            out_data_r.sounding <= res_sounding_r;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KTS_ASSERT_IMPL(a_env_range, 1'b1, env_r <= kts_pkg::ENV_ONE, "envelope above full scale")
  `KTS_ASSERT_NEXT(a_idle_keeps_env, in_xfer && silent, state_r == S_EMIT && env_r == $past(env_r), "idle tick disturbed envelope")
  `KTS_ASSERT_IMPL(a_mul_done_state, mul_done, state_r == S_ENV || state_r == S_MAG || state_r == S_AMP, "multiplier finished outside a pass")
  `KTS_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_r), $past(state_r == S_EMIT), "result presented without emit")

endmodule
